// File: rtl/pms_pkg.sv
// shared types, codes and defaults of the partitioned multi-stack unit
package pms_pkg;

    localparam int DEF_STORE_DEPTH = 64;
    localparam int DEF_MAX_STACKS  = 8;
    localparam int MAX_RESULTS     = 64;

    localparam logic [1:0] MODE_PUSH    = 2'd0;
    localparam logic [1:0] MODE_POP     = 2'd1;
    localparam logic [1:0] MODE_DISPLAY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DATA
    } pms_state_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         stack_number;
        logic signed [31:0] push_value;
    } pms_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } pms_rsp_t;

    typedef struct packed {
        logic inc;
        logic dec;
    } pms_occ_op_t;

endpackage

// File: rtl/pms_word_mem.sv
// shared word store: one write port, one registered read port
module pms_word_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pms_part.sv
// partition table: stack count, span, per-stack occupancy and bound lookup
module pms_part
    import pms_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int MAX_STACKS  = DEF_MAX_STACKS,
    parameter int PW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [3:0]    cfg_data,
    input  logic          lookup,
    input  logic [2:0]    stack_number,
    input  pms_occ_op_t   op,
    output logic [PW-1:0] base,
    output logic [PW-1:0] size,
    output logic [PW-1:0] occ,
    output logic          bad
);

    localparam int NW = $clog2(MAX_STACKS + 1);
    localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int XW = (NW > 3) ? NW : 3;

    logic [NW-1:0] num_reg;
    logic [PW-1:0] span_reg;
    logic [PW-1:0] occ_reg [MAX_STACKS];
    logic [SW-1:0] sel_reg;
    logic [PW-1:0] base_reg;
    logic [PW-1:0] size_reg;
    logic [PW-1:0] occ_out_reg;
    logic          bad_reg;

    logic [PW-1:0] span_tab [MAX_STACKS + 1];
    logic [NW-1:0] cnt;
    logic [XW-1:0] sn_x;
    logic [XW-1:0] num_x;
    logic [SW-1:0] sel;
    logic [PW+2:0] prod;
    logic [PW-1:0] base_c;
    logic [PW-1:0] size_c;

    // span for each possible stack count, fixed at elaboration
    assign span_tab[0] = PW'(STORE_DEPTH);
    for (genvar g = 1; g <= MAX_STACKS; g++)
    begin : g_span
        localparam int SPAN_G = STORE_DEPTH / g;
        assign span_tab[g] = PW'(SPAN_G);
    end

    // clamp the written count into 1..MAX_STACKS
    always_comb
    begin
        if (cfg_data == 4'd0)
        begin
            cnt = NW'(1);
        end
        else if (32'(cfg_data) > MAX_STACKS)
        begin
            cnt = NW'(MAX_STACKS);
        end
        else
        begin
            cnt = NW'(cfg_data);
        end
    end

    assign sn_x   = XW'(stack_number);
    assign num_x  = XW'(num_reg);
    assign sel    = SW'(stack_number);
    assign prod   = (PW+3)'(span_reg) * (PW+3)'(stack_number);
    assign base_c = prod[PW-1:0];
    assign size_c = (sn_x + XW'(1) == num_x) ? PW'(STORE_DEPTH) - base_c : span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= NW'(1);
            span_reg <= PW'(STORE_DEPTH);
            for (int k = 0; k < MAX_STACKS; k++)
            begin
                occ_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            num_reg  <= cnt;
            span_reg <= span_tab[cnt];
            for (int k = 0; k < MAX_STACKS; k++)
            begin
                occ_reg[k] <= '0;
            end
        end
        else if (op.inc)
        begin
            occ_reg[sel_reg] <= occ_reg[sel_reg] + PW'(1);
        end
        else if (op.dec)
        begin
            occ_reg[sel_reg] <= occ_reg[sel_reg] - PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            sel_reg     <= sel;
            base_reg    <= base_c;
            size_reg    <= size_c;
            occ_out_reg <= occ_reg[sel];
            bad_reg     <= (sn_x >= num_x);
        end
    end

    assign base = base_reg;
    assign size = size_reg;
    assign occ  = occ_out_reg;
    assign bad  = bad_reg;

endmodule

// File: rtl/partitioned_multi_stack_unit.sv
// top level of the partitioned multi-stack unit: sequencer and output register
//
// several stacks share one word store, split into equal partitions with the
// remainder going to the last one
// request channel: req_valid / req_stall / req (mode, stack_number, push_value)
// response channel: rsp_valid / rsp_stall / rsp (value, status, last)
// cfg_we with cfg_data writes the stack count (0 taken as 1, clamped above),
// re-partitions the store and empties every stack
// a push or pop goes through the bound lookup and multiply, then the store
// access, which waits while the response side is stalled; a pop then also
// waits for the store read
// a display returns at most MAX_RESULTS words, paced by the single read
// port of the word store
// one request is in flight at a time; req_stall stays high until it is done
// a stalled response holds in the output register and the sequencer waits
// reset leaves one empty stack spanning the whole store; the store itself
// is not cleared, since no word is read before it is pushed
module partitioned_multi_stack_unit
    import pms_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int MAX_STACKS  = DEF_MAX_STACKS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  pms_req_t   req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output pms_rsp_t   rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    pms_state_t    state_reg;
    pms_state_t    state_next;
    pms_req_t      req_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic          rsp_valid_reg;
    pms_rsp_t      rsp_reg;

    logic          accept;
    logic          out_free;
    logic          emit;
    pms_rsp_t      emit_rsp;
    pms_occ_op_t   op;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic [PW-1:0] base;
    logic [PW-1:0] size;
    logic [PW-1:0] occ;
    logic          bad;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    // the output register may take a new response this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    pms_part #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STACKS  (MAX_STACKS),
        .PW          (PW)
    ) u_part (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .lookup       (accept),
        .stack_number (req.stack_number),
        .op           (op),
        .base         (base),
        .size         (size),
        .occ          (occ),
        .bad          (bad)
    );

    pms_word_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req_reg.push_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer: lookup on accept, store access in exec, word walk in data
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        emit_rsp   = '0;
        op         = '0;
        mem_we     = 1'b0;
        mem_waddr  = AW'(base + occ);
        mem_re     = 1'b0;
        mem_raddr  = AW'(base + occ - PW'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg.mode != MODE_PUSH && req_reg.mode != MODE_POP
                    && req_reg.mode != MODE_DISPLAY)
                begin
                    // unused mode: no response
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit_rsp.last = 1'b1;
                    if (bad)
                    begin
                        emit            = 1'b1;
                        emit_rsp.status = STAT_BAD;
                        state_next      = ST_IDLE;
                    end
                    else if (req_reg.mode == MODE_PUSH)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                        if (occ < size)
                        begin
                            mem_we          = 1'b1;
                            op.inc          = 1'b1;
                            emit_rsp.status = STAT_OK;
                        end
                        else
                        begin
                            emit_rsp.status = STAT_FULL;
                        end
                    end
                    else if (occ == '0)
                    begin
                        emit            = 1'b1;
                        emit_rsp.status = STAT_EMPTY;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the top word; pop shrinks the stack now
                        mem_re     = 1'b1;
                        ptr_next   = mem_raddr;
                        state_next = ST_DATA;
                        if (req_reg.mode == MODE_POP)
                        begin
                            op.dec   = 1'b1;
                            rem_next = RW'(1);
                        end
                        else if (32'(occ) > MAX_RESULTS)
                        begin
                            rem_next = RW'(MAX_RESULTS);
                        end
                        else
                        begin
                            rem_next = RW'(occ);
                        end
                    end
                end
            end
            ST_DATA:
            begin
                mem_raddr = ptr_reg - AW'(1);
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_rsp.value  = mem_rdata;
                    emit_rsp.status = STAT_OK;
                    emit_rsp.last   = (rem_reg == RW'(1));
                    if (rem_reg == RW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // next word down, read while this one goes out
                        mem_re   = 1'b1;
                        ptr_next = ptr_reg - AW'(1);
                        rem_next = rem_reg - RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        ptr_reg <= ptr_next;
        rem_reg <= rem_next;
        if (emit)
        begin
            rsp_reg <= emit_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
